### sv/bbas_pkg.sv
// ----------------------------------------------------------------------------
// bbas_pkg: shared types and codes of the buzzer/backlight alarm sequencer
// Command codes, register indexes, register reset values and field types.
// ----------------------------------------------------------------------------
package bbas_pkg;

   typedef logic [2:0]  cmd_type;
   typedef logic [31:0] time_type;
   typedef logic [15:0] ms_type;
   typedef logic [1:0]  csr_idx_type;

   // command codes
   localparam cmd_type CMD_TICK         = 3'd0;
   localparam cmd_type CMD_FAST_BEEP    = 3'd1;
   localparam cmd_type CMD_SLOW_BEEP    = 3'd2;
   localparam cmd_type CMD_BEEP_REP_ON  = 3'd3;
   localparam cmd_type CMD_BEEP_REP_OFF = 3'd4;
   localparam cmd_type CMD_BLINK        = 3'd5;
   localparam cmd_type CMD_BLINK_REP_ON = 3'd6;
   localparam cmd_type CMD_BLINK_REP_OFF = 3'd7;

   // register indexes
   localparam csr_idx_type CSR_HALF_PERIOD = 2'd0;
   localparam csr_idx_type CSR_FAST_BEEP   = 2'd1;
   localparam csr_idx_type CSR_SLOW_BEEP   = 2'd2;
   localparam csr_idx_type CSR_BLINK       = 2'd3;

   // register reset values
   localparam ms_type HALF_PERIOD_RST = 16'd250;
   localparam ms_type FAST_BEEP_RST   = 16'd100;
   localparam ms_type SLOW_BEEP_RST   = 16'd500;
   localparam ms_type BLINK_RST       = 16'd200;

endpackage

### sv/bbas_if.sv
// ----------------------------------------------------------------------------
// bbas_if: item channels of the alarm sequencer
// Request channel (command and time) and result channel (pin levels, status).
// ----------------------------------------------------------------------------
interface bbas_req_if;
   logic               valid;
   logic               ready;
   bbas_pkg::cmd_type  command;
   bbas_pkg::time_type now_ms;

   modport source (output valid, output command, output now_ms, input ready);
   modport sink   (input valid, input command, input now_ms, output ready);
endinterface

interface bbas_rsp_if;
   logic valid;
   logic ready;
   logic buzzer_level;
   logic backlight_level;
   logic beep_active;
   logic blink_active;

   modport source (output valid, output buzzer_level, output backlight_level,
                   output beep_active, output blink_active, input ready);
   modport sink   (input valid, input buzzer_level, input backlight_level,
                   input beep_active, input blink_active, output ready);
endinterface

### sv/buzzer_backlight_alarm_sequencer.sv
// ----------------------------------------------------------------------------
// buzzer_backlight_alarm_sequencer: buzzer square wave and backlight blinker
// Applies command and tick items to the beep and blink channels, one result
// item per request item.
// ----------------------------------------------------------------------------
// The block takes one request item per clock cycle except while a result
// is stalled and the input register is full, and returns one result item
// for each, in order: the item is held in an input register, applied to the
// channel state by a single pass of compare and update logic, and the pin
// levels and channel status are captured in a result register. The request
// side keeps accepting while a result waits, as long as the input register
// is free. Register writes on the csr_ port take effect at the next clock
// edge and should be made while no item is in flight.
module buzzer_backlight_alarm_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  bbas_pkg::csr_idx_type   csr_index,
   input  bbas_pkg::ms_type        csr_wdata,
   bbas_req_if.sink                req_ch,
   bbas_rsp_if.source              rsp_ch
);

   // configuration registers
   bbas_pkg::ms_type   half_period_ff, fast_beep_ff, slow_beep_ff, blink_ms_ff;

   // input stage
   logic               in_valid_ff;
   bbas_pkg::cmd_type  in_cmd_ff;
   bbas_pkg::time_type in_now_ff;

   // channel state
   logic               beep_en_ff, blink_en_ff, beep_rep_ff, blink_rep_ff;
   logic               beep_init_ff, blink_init_ff, beep_on_ff;
   logic               buzzer_ff, backlight_ff;
   bbas_pkg::time_type beep_time_ff, blink_time_ff;

   logic               beep_en_in, blink_en_in, beep_rep_in, blink_rep_in;
   logic               beep_init_in, blink_init_in, beep_on_in;
   logic               buzzer_in, backlight_in;
   bbas_pkg::time_type beep_time_in, blink_time_in;

   // result stage
   logic               rsp_valid_ff;
   logic               rsp_buzzer_ff, rsp_backlight_ff, rsp_beep_ff, rsp_blink_ff;

   logic               advance;
   logic               step;
   bbas_pkg::time_type half_period_ext;
   bbas_pkg::time_type beep_ref;
   bbas_pkg::time_type blink_ref;
   logic               beep_on_flip;

   assign advance         = !rsp_valid_ff || rsp_ch.ready;
   assign step            = in_valid_ff && advance;
   assign req_ch.ready    = !in_valid_ff || advance;
   assign half_period_ext = {16'd0, half_period_ff};

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= bbas_pkg::HALF_PERIOD_RST;
         fast_beep_ff   <= bbas_pkg::FAST_BEEP_RST;
         slow_beep_ff   <= bbas_pkg::SLOW_BEEP_RST;
         blink_ms_ff    <= bbas_pkg::BLINK_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bbas_pkg::CSR_HALF_PERIOD: half_period_ff <= csr_wdata;
            bbas_pkg::CSR_FAST_BEEP:   fast_beep_ff   <= csr_wdata;
            bbas_pkg::CSR_SLOW_BEEP:   slow_beep_ff   <= csr_wdata;
            bbas_pkg::CSR_BLINK:       blink_ms_ff    <= csr_wdata;
            default:                   half_period_ff <= half_period_ff;
         endcase
      end
   end

   // hold the accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_cmd_ff <= req_ch.command;
         in_now_ff <= req_ch.now_ms;
      end
   end

   // apply one item to the channel state
   always_comb begin
      beep_en_in    = beep_en_ff;
      blink_en_in   = blink_en_ff;
      beep_rep_in   = beep_rep_ff;
      blink_rep_in  = blink_rep_ff;
      beep_init_in  = beep_init_ff;
      blink_init_in = blink_init_ff;
      beep_on_in    = beep_on_ff;
      buzzer_in     = buzzer_ff;
      backlight_in  = backlight_ff;
      beep_time_in  = beep_time_ff;
      blink_time_in = blink_time_ff;
      beep_ref      = beep_time_ff;
      blink_ref     = blink_time_ff;
      beep_on_flip  = beep_on_ff;

      unique case (in_cmd_ff)
         bbas_pkg::CMD_TICK: begin
            // advance the beep channel first; blink may align to its time
            if (beep_en_ff) begin
               if (beep_rep_ff) begin
                  if (!beep_init_ff && blink_rep_ff && blink_init_ff) begin
                     beep_ref = blink_time_ff;
                  end
                  beep_init_in = 1'b1;
                  beep_time_in = beep_ref;
                  beep_on_flip = beep_on_ff;
                  buzzer_in    = buzzer_ff;
                  if ((in_now_ff - beep_ref) > half_period_ext) begin
                     beep_on_flip = !beep_on_ff;
                     if (beep_on_ff) begin
                        buzzer_in = 1'b0;
                     end
                     beep_time_in = in_now_ff;
                  end
                  beep_on_in = beep_on_flip;
                  if (beep_on_flip) begin
                     buzzer_in = !buzzer_in;
                  end
               end else if (beep_init_ff) begin
                  if (in_now_ff >= beep_time_ff) begin
                     buzzer_in  = 1'b0;
                     beep_en_in = 1'b0;
                  end else begin
                     buzzer_in = !buzzer_ff;
                  end
               end else begin
                  beep_time_in = beep_time_ff + in_now_ff;
                  beep_init_in = 1'b1;
                  buzzer_in    = !buzzer_ff;
               end
            end
            if (blink_en_ff) begin
               if (blink_rep_ff) begin
                  if (!blink_init_ff && beep_rep_ff) begin
                     blink_ref = beep_time_in;
                  end
                  blink_init_in = 1'b1;
                  blink_time_in = blink_ref;
                  if ((in_now_ff - blink_ref) > half_period_ext) begin
                     backlight_in  = !backlight_ff;
                     blink_time_in = in_now_ff;
                  end
               end else if (blink_init_ff) begin
                  if (in_now_ff >= blink_time_ff) begin
                     backlight_in = 1'b1;
                     blink_en_in  = 1'b0;
                  end
               end else begin
                  blink_time_in = blink_time_ff + in_now_ff;
                  backlight_in  = 1'b0;
                  blink_init_in = 1'b1;
               end
            end
         end
         bbas_pkg::CMD_FAST_BEEP, bbas_pkg::CMD_SLOW_BEEP: begin
            if (!beep_en_ff) begin
               beep_time_in = (in_cmd_ff == bbas_pkg::CMD_FAST_BEEP) ?
                              {16'd0, fast_beep_ff} : {16'd0, slow_beep_ff};
               beep_en_in   = 1'b1;
               beep_init_in = 1'b0;
            end
         end
         bbas_pkg::CMD_BEEP_REP_ON: begin
            if (!beep_en_ff) begin
               beep_time_in = '0;
               beep_en_in   = 1'b1;
               beep_rep_in  = 1'b1;
               beep_on_in   = 1'b1;
               beep_init_in = 1'b0;
            end
         end
         bbas_pkg::CMD_BEEP_REP_OFF: begin
            if (beep_rep_ff) begin
               beep_en_in  = 1'b0;
               beep_rep_in = 1'b0;
            end
         end
         bbas_pkg::CMD_BLINK: begin
            if (!blink_en_ff) begin
               blink_time_in = {16'd0, blink_ms_ff};
               blink_en_in   = 1'b1;
               blink_init_in = 1'b0;
            end
         end
         bbas_pkg::CMD_BLINK_REP_ON: begin
            if (!blink_en_ff) begin
               blink_time_in = '0;
               blink_en_in   = 1'b1;
               blink_rep_in  = 1'b1;
               blink_init_in = 1'b0;
            end
         end
         bbas_pkg::CMD_BLINK_REP_OFF: begin
            if (blink_rep_ff) begin
               blink_en_in  = 1'b0;
               blink_rep_in = 1'b0;
            end
         end
         default: begin
            beep_en_in = beep_en_ff;
         end
      endcase
   end

   // update channel state as the item moves to the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         beep_en_ff    <= 1'b0;
         blink_en_ff   <= 1'b0;
         beep_rep_ff   <= 1'b0;
         blink_rep_ff  <= 1'b0;
         beep_init_ff  <= 1'b0;
         blink_init_ff <= 1'b0;
         beep_on_ff    <= 1'b0;
         buzzer_ff     <= 1'b0;
         backlight_ff  <= 1'b1;
         beep_time_ff  <= '0;
         blink_time_ff <= '0;
      end else if (step) begin
         beep_en_ff    <= beep_en_in;
         blink_en_ff   <= blink_en_in;
         beep_rep_ff   <= beep_rep_in;
         blink_rep_ff  <= blink_rep_in;
         beep_init_ff  <= beep_init_in;
         blink_init_ff <= blink_init_in;
         beep_on_ff    <= beep_on_in;
         buzzer_ff     <= buzzer_in;
         backlight_ff  <= backlight_in;
         beep_time_ff  <= beep_time_in;
         blink_time_ff <= blink_time_in;
      end
   end

   // capture the result item
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_buzzer_ff    <= buzzer_in;
         rsp_backlight_ff <= backlight_in;
         rsp_beep_ff      <= beep_en_in;
         rsp_blink_ff     <= blink_en_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.buzzer_level    = rsp_buzzer_ff;
   assign rsp_ch.backlight_level = rsp_backlight_ff;
   assign rsp_ch.beep_active     = rsp_beep_ff;
   assign rsp_ch.blink_active    = rsp_blink_ff;

endmodule

### sv/bbas_checker.sv
// ----------------------------------------------------------------------------
// bbas_checker: port-level checks of the alarm sequencer
// Watches the request and result channels and reports by $error.
// ----------------------------------------------------------------------------
module bbas_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_buzzer,
   input logic rsp_backlight,
   input logic rsp_beep,
   input logic rsp_blink
);

   // result channel holds a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_buzzer) && $stable(rsp_backlight)
                                  && $stable(rsp_beep) && $stable(rsp_blink))
      else $error("stalled result item changed");

   // request side stalls only behind a waiting result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request side stalled with result side free");

   // reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

bind buzzer_backlight_alarm_sequencer bbas_checker u_bbas_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_buzzer    (rsp_ch.buzzer_level),
   .rsp_backlight (rsp_ch.backlight_level),
   .rsp_beep      (rsp_ch.beep_active),
   .rsp_blink     (rsp_ch.blink_active)
);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: buzzer/backlight alarm sequencer
// Drives command and tick items through the request channel and checks every
// result item against a cycle-free model of the beep and blink channels. A
// short directed table runs first, followed by random phases that change the
// timing registers and the idle pattern of both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 330;
   localparam int PHASES       = 6;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 4;
   localparam int MAX_REPORTS  = 10;

   // one result item: buzzer, backlight, beep enabled, blink enabled
   typedef struct packed {
      logic buzzer_level;
      logic backlight_level;
      logic beep_active;
      logic blink_active;
   } levels_type;

   // directed row: command, time, fixed expectation present, expectation
   typedef struct packed {
      bbas_pkg::cmd_type  cmd;
      bbas_pkg::time_type now;
      logic               fixed;
      levels_type         lv;
   } dir_row_type;

   typedef struct packed {
      logic beep_en;
      logic blink_en;
      logic beep_rep;
      logic blink_rep;
      logic beep_init;
      logic blink_init;
      logic beep_on;
   } chan_flags_type;

   // levels column: buzzer, backlight, beep_active, blink_active
   localparam dir_row_type DIR_ROWS [24] = '{
      '{bbas_pkg::CMD_TICK,          32'd0,          1'b1, 4'b0100},
      '{bbas_pkg::CMD_FAST_BEEP,     32'hFFFF_FFFF,  1'b1, 4'b0110},
      '{bbas_pkg::CMD_SLOW_BEEP,     32'd0,          1'b1, 4'b0110},
      '{bbas_pkg::CMD_TICK,          32'd1000,       1'b1, 4'b1110},
      '{bbas_pkg::CMD_TICK,          32'd1050,       1'b1, 4'b0110},
      '{bbas_pkg::CMD_TICK,          32'd1100,       1'b1, 4'b0100},
      '{bbas_pkg::CMD_BEEP_REP_OFF,  32'd0,          1'b1, 4'b0100},
      '{bbas_pkg::CMD_BLINK,         32'd0,          1'b1, 4'b0101},
      '{bbas_pkg::CMD_TICK,          32'd2000,       1'b1, 4'b0001},
      '{bbas_pkg::CMD_BLINK_REP_ON,  32'd0,          1'b1, 4'b0001},
      '{bbas_pkg::CMD_TICK,          32'd2200,       1'b1, 4'b0100},
      '{bbas_pkg::CMD_BLINK_REP_OFF, 32'd0,          1'b1, 4'b0100},
      '{bbas_pkg::CMD_SLOW_BEEP,     32'd0,          1'b0, 4'b0000},
      '{bbas_pkg::CMD_TICK,          32'hFFFF_FFFF,  1'b0, 4'b0000},
      '{bbas_pkg::CMD_TICK,          32'd0,          1'b0, 4'b0000},
      '{bbas_pkg::CMD_TICK,          32'd499,        1'b0, 4'b0000},
      '{bbas_pkg::CMD_BEEP_REP_ON,   32'd0,          1'b0, 4'b0000},
      '{bbas_pkg::CMD_BLINK_REP_ON,  32'hFFFF_FFFF,  1'b0, 4'b0000},
      '{bbas_pkg::CMD_TICK,          32'd100,        1'b0, 4'b0000},
      '{bbas_pkg::CMD_TICK,          32'd300,        1'b0, 4'b0000},
      '{bbas_pkg::CMD_TICK,          32'd600,        1'b0, 4'b0000},
      '{bbas_pkg::CMD_BEEP_REP_OFF,  32'd0,          1'b0, 4'b0000},
      '{bbas_pkg::CMD_BLINK_REP_OFF, 32'd0,          1'b0, 4'b0000},
      '{bbas_pkg::CMD_TICK,          32'hFFFF_FFFF,  1'b0, 4'b0000}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   bbas_pkg::csr_idx_type csr_index;
   bbas_pkg::ms_type      csr_wdata;

   bbas_req_if req_ch ();
   bbas_rsp_if rsp_ch ();

   buzzer_backlight_alarm_sequencer u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   always #5 clock = ~clock;

   // model state and register copies
   bbas_pkg::ms_type   half_ms, fast_ms, slow_ms, blink_len_ms;
   chan_flags_type     flags;
   bbas_pkg::time_type beep_mark, blink_mark;
   logic               buzzer_pin, backlight_pin;

   levels_type levels_q [$];
   int         mismatches    = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   bit         hold_req      = 1'b0;
   int         hold_left     = 0;
   int         stall_cycles  = 0;

   // apply one item to the channel model and return the pin levels
   task automatic advance_alarm(input bbas_pkg::cmd_type cmd,
                                input bbas_pkg::time_type now,
                                output levels_type lv);
      bbas_pkg::time_type gap;
      case (cmd)
         bbas_pkg::CMD_TICK: begin
            if (flags.beep_en) begin
               if (flags.beep_rep) begin
                  // align with the blink phase on the first repeating tick
                  if (!flags.beep_init) begin
                     if (flags.blink_rep && flags.blink_init)
                        beep_mark = blink_mark;
                     flags.beep_init = 1'b1;
                  end
                  gap = now - beep_mark;
                  if (gap > bbas_pkg::time_type'(half_ms)) begin
                     flags.beep_on = ~flags.beep_on;
                     if (!flags.beep_on)
                        buzzer_pin = 1'b0;
                     beep_mark = now;
                  end
                  if (flags.beep_on)
                     buzzer_pin = ~buzzer_pin;
               end else if (flags.beep_init) begin
                  // end the single beep once the deadline is reached
                  if (now >= beep_mark) begin
                     buzzer_pin    = 1'b0;
                     flags.beep_en = 1'b0;
                  end else begin
                     buzzer_pin = ~buzzer_pin;
                  end
               end else begin
                  beep_mark       = beep_mark + now;
                  flags.beep_init = 1'b1;
                  buzzer_pin      = ~buzzer_pin;
               end
            end
            if (flags.blink_en) begin
               if (flags.blink_rep) begin
                  if (!flags.blink_init) begin
                     if (flags.beep_rep)
                        blink_mark = beep_mark;
                     flags.blink_init = 1'b1;
                  end
                  gap = now - blink_mark;
                  if (gap > bbas_pkg::time_type'(half_ms)) begin
                     backlight_pin = ~backlight_pin;
                     blink_mark    = now;
                  end
               end else if (flags.blink_init) begin
                  if (now >= blink_mark) begin
                     backlight_pin  = 1'b1;
                     flags.blink_en = 1'b0;
                  end
               end else begin
                  blink_mark       = blink_mark + now;
                  backlight_pin    = 1'b0;
                  flags.blink_init = 1'b1;
               end
            end
         end
         bbas_pkg::CMD_FAST_BEEP, bbas_pkg::CMD_SLOW_BEEP: begin
            if (!flags.beep_en) begin
               beep_mark       = (cmd == bbas_pkg::CMD_FAST_BEEP) ?
                                 bbas_pkg::time_type'(fast_ms) :
                                 bbas_pkg::time_type'(slow_ms);
               flags.beep_en   = 1'b1;
               flags.beep_init = 1'b0;
            end
         end
         bbas_pkg::CMD_BEEP_REP_ON: begin
            if (!flags.beep_en) begin
               beep_mark       = '0;
               flags.beep_en   = 1'b1;
               flags.beep_rep  = 1'b1;
               flags.beep_on   = 1'b1;
               flags.beep_init = 1'b0;
            end
         end
         bbas_pkg::CMD_BEEP_REP_OFF: begin
            if (flags.beep_rep) begin
               flags.beep_en  = 1'b0;
               flags.beep_rep = 1'b0;
            end
         end
         bbas_pkg::CMD_BLINK: begin
            if (!flags.blink_en) begin
               blink_mark       = bbas_pkg::time_type'(blink_len_ms);
               flags.blink_en   = 1'b1;
               flags.blink_init = 1'b0;
            end
         end
         bbas_pkg::CMD_BLINK_REP_ON: begin
            if (!flags.blink_en) begin
               blink_mark       = '0;
               flags.blink_en   = 1'b1;
               flags.blink_rep  = 1'b1;
               flags.blink_init = 1'b0;
            end
         end
         default: begin
            if (flags.blink_rep) begin
               flags.blink_en  = 1'b0;
               flags.blink_rep = 1'b0;
            end
         end
      endcase
      lv = '{buzzer_pin, backlight_pin, flags.beep_en, flags.blink_en};
   endtask

   // offer one item, wait for acceptance, queue its expected result
   task automatic send_item(input bbas_pkg::cmd_type cmd, input bbas_pkg::time_type now,
                            input logic fixed, input levels_type lv);
      levels_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.now_ms  <= now;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      advance_alarm(cmd, now, predicted);
      levels_q.push_back(fixed ? lv : predicted);
      @(negedge clock);
   endtask

   // write one timing register and mirror it in the model
   task automatic write_csr(input bbas_pkg::csr_idx_type idx, input bbas_pkg::ms_type val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         bbas_pkg::CSR_HALF_PERIOD: half_ms      = val;
         bbas_pkg::CSR_FAST_BEEP:   fast_ms      = val;
         bbas_pkg::CSR_SLOW_BEEP:   slow_ms      = val;
         default:                   blink_len_ms = val;
      endcase
      @(negedge clock);
   endtask

   // drop valid and wait until every expected result has come back
   task automatic drain;
      req_ch.valid <= 1'b0;
      while (levels_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // result side: random stalls, plus one long hold on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // check each accepted result against the oldest expectation
   always @(posedge clock) begin
      levels_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.buzzer_level, rsp_ch.backlight_level,
                 rsp_ch.beep_active, rsp_ch.blink_active};
         if (levels_q.size() == 0) begin
            if (mismatches < MAX_REPORTS)
               $display("unexpected result item: buzzer/backlight/beep/blink=%b", got);
            mismatches++;
         end else begin
            want = levels_q.pop_front();
            if (got !== want) begin
               if (mismatches < MAX_REPORTS)
                  $display("mismatch: buzzer/backlight/beep/blink expected %b, got %b",
                           want, got);
               mismatches++;
            end
         end
      end
   end

   // end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int                 phase, i, r, step_max;
      bbas_pkg::time_type wall_ms;
      bbas_pkg::ms_type   c_half, c_fast, c_slow, c_blink;

      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = bbas_pkg::CSR_HALF_PERIOD;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.command = bbas_pkg::CMD_TICK;
      req_ch.now_ms  = '0;
      rsp_ch.ready   = 1'b0;

      half_ms       = bbas_pkg::HALF_PERIOD_RST;
      fast_ms       = bbas_pkg::FAST_BEEP_RST;
      slow_ms       = bbas_pkg::SLOW_BEEP_RST;
      blink_len_ms  = bbas_pkg::BLINK_RST;
      flags         = '0;
      beep_mark     = '0;
      blink_mark    = '0;
      buzzer_pin    = 1'b0;
      backlight_pin = 1'b1;
      wall_ms       = '0;

      send_idle_pct = 13;
      recv_idle_pct = 68;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table at reset register values
      foreach (DIR_ROWS[k])
         send_item(DIR_ROWS[k].cmd, DIR_ROWS[k].now, DIR_ROWS[k].fixed, DIR_ROWS[k].lv);
      drain();

      for (phase = 0; phase < PHASES; phase++) begin
         // swap idle pattern every two phases, no idling at the end
         case (phase / 2)
            0:       begin send_idle_pct = 13; recv_idle_pct = 68; end
            1:       begin send_idle_pct = 68; recv_idle_pct = 13; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase

         case (phase)
            0: begin
               c_half = 16'd1; c_fast = 16'd1; c_slow = 16'd1; c_blink = 16'd1;
            end
            2: begin
               c_half = 16'hFFFF; c_fast = 16'hFFFF;
               c_slow = 16'hFFFF; c_blink = 16'hFFFF;
            end
            4: begin
               c_half = 16'd1; c_fast = 16'hFFFF; c_slow = 16'd1; c_blink = 16'hFFFF;
            end
            5: begin
               c_half = bbas_pkg::HALF_PERIOD_RST; c_fast  = bbas_pkg::FAST_BEEP_RST;
               c_slow = bbas_pkg::SLOW_BEEP_RST;   c_blink = bbas_pkg::BLINK_RST;
            end
            default: begin
               c_half  = bbas_pkg::ms_type'($urandom_range(1, 600));
               c_fast  = bbas_pkg::ms_type'($urandom_range(1, 600));
               c_slow  = bbas_pkg::ms_type'($urandom_range(1, 600));
               c_blink = bbas_pkg::ms_type'($urandom_range(1, 600));
            end
         endcase
         write_csr(bbas_pkg::CSR_HALF_PERIOD, c_half);
         write_csr(bbas_pkg::CSR_FAST_BEEP, c_fast);
         write_csr(bbas_pkg::CSR_SLOW_BEEP, c_slow);
         write_csr(bbas_pkg::CSR_BLINK, c_blink);
         csr_wr_en <= 1'b0;

         // scale the tick step so single events expire within the phase
         step_max = c_half;
         if (c_fast > step_max)  step_max = c_fast;
         if (c_slow > step_max)  step_max = c_slow;
         if (c_blink > step_max) step_max = c_blink;
         step_max = step_max / 8 + 2;

         // hold the result side long enough to back up the input
         if (phase == 1) begin
            @(posedge clock);
            hold_req = 1'b1;
            @(negedge clock);
         end

         for (i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 60) begin
               // advance time mostly forward, with rare jumps and wraps
               r = $urandom_range(0, 99);
               if (r < 2)
                  wall_ms = $urandom();
               else if (r < 4)
                  wall_ms = 32'hFFFF_FFFF - $urandom_range(0, step_max);
               else
                  wall_ms = wall_ms + $urandom_range(0, step_max);
               send_item(bbas_pkg::CMD_TICK, wall_ms, 1'b0, '0);
            end else begin
               send_item(bbas_pkg::cmd_type'($urandom_range(1, 7)), $urandom(), 1'b0, '0);
            end
         end
         drain();
      end

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### sim.f
sv/bbas_pkg.sv
sv/bbas_if.sv
sv/buzzer_backlight_alarm_sequencer.sv
sv/bbas_checker.sv
dv/testbench.sv
